// ===== rtl/core/lpmd_pkg.sv =====
// Shared types and constants for the length-prefixed message deframer.
// Used by lpmd_parser, lpmd_out_buf and length_prefixed_message_deframer.
// No other dependencies.
`default_nettype none

package lpmd_pkg;

    localparam int unsigned BYTE_W       = 8;
    localparam int unsigned FIELD_W      = 16;
    localparam int unsigned MAX_W        = 17;
    localparam int unsigned KIND_W       = 2;
    localparam int unsigned TDATA_W      = 2 * FIELD_W + BYTE_W;

    localparam logic [MAX_W-1:0] HEADER_BYTES  = 17'd4;
    localparam logic [MAX_W-1:0] MAX_MSG_RESET = 17'd1024;

    // Header byte positions, little-endian type then length.
    localparam logic [1:0] HDR_TYPE_LO = 2'd0;
    localparam logic [1:0] HDR_TYPE_HI = 2'd1;
    localparam logic [1:0] HDR_LEN_LO  = 2'd2;
    localparam logic [1:0] HDR_LEN_HI  = 2'd3;

    localparam logic [KIND_W-1:0] KIND_PAYLOAD = 2'd0;
    localparam logic [KIND_W-1:0] KIND_EMPTY   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DROPPED = 2'd2;

    typedef enum logic [2:0] {
        PH_HEADER  = 3'b001,
        PH_FORWARD = 3'b010,
        PH_DISCARD = 3'b100
    } phase_t;

    typedef struct packed {
        logic [FIELD_W-1:0] msg_type;
        logic [FIELD_W-1:0] payload_len;
        logic [BYTE_W-1:0]  data_byte;
        logic [KIND_W-1:0]  kind;
        logic               last;
    } result_t;

    typedef struct packed {
        logic    valid;
        result_t data;
    } result_slot_t;

endpackage

`default_nettype wire

// ===== rtl/core/length_prefixed_message_deframer.sv =====
// Top level of the length-prefixed message deframer.
// Holds the input byte register and the size limit register; uses lpmd_pkg,
// lpmd_parser and lpmd_out_buf.
//
// Takes one byte per item and strips a 4-byte little-endian header (16-bit type,
// then 16-bit payload length). Each payload byte leaves as one item tagged with
// type and length, tlast on the final byte. An empty message gives one item of
// kind "empty"; a message larger than max_message_bytes (header included, values
// below 4 act as 4) gives one "dropped" item when its header completes and its
// payload is then swallowed. The block takes one byte every cycle while the output
// buffer has room: a byte is held in the input register, the parser updates its
// counters and forms the result combinationally from it, and the result enters a
// two-entry output buffer whose head register drives the master side. Slave-side
// ready depends only on registered state: input valid and buffer occupancy.
// max_message_bytes is written through cfg_valid/cfg_data (cfg_ready is always
// high) and resets to 1024.
`default_nettype none

module length_prefixed_message_deframer (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    input  wire logic [7:0]                         s_axis_tdata,   // [7:0] byte_in
    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    // [15:0] msg_type, [31:16] payload_len, [39:32] data_byte
    output logic [lpmd_pkg::TDATA_W-1:0]            m_axis_tdata,
    output logic [lpmd_pkg::KIND_W-1:0]             m_axis_tuser,   // [1:0] kind
    output logic                                    m_axis_tlast,
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [lpmd_pkg::MAX_W-1:0]         cfg_data
);

    logic                               in_valid_reg;
    logic [lpmd_pkg::BYTE_W-1:0]        in_byte_reg;
    logic [lpmd_pkg::MAX_W-1:0]         max_bytes_reg;
    logic                               room;
    logic                               step;
    lpmd_pkg::result_slot_t             result;
    lpmd_pkg::result_t                  out_item;

    assign cfg_ready     = 1'b1;
    assign step          = in_valid_reg & room;
    assign s_axis_tready = ~in_valid_reg | room;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            max_bytes_reg <= lpmd_pkg::MAX_MSG_RESET;
        end
        else
        begin
            if (s_axis_tready)
            begin
                in_valid_reg <= s_axis_tvalid;
            end
            if (cfg_valid)
            begin
                max_bytes_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_byte_reg <= s_axis_tdata;
        end
    end

    lpmd_parser u_parser (
        .clk               (clk),
        .rst_n             (rst_n),
        .step              (step),
        .byte_in           (in_byte_reg),
        .max_message_bytes (max_bytes_reg),
        .result            (result)
    );

    lpmd_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_item (result),
        .room      (room),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_item  (out_item)
    );

    assign m_axis_tdata = {out_item.data_byte, out_item.payload_len, out_item.msg_type};
    assign m_axis_tuser = out_item.kind;
    assign m_axis_tlast = out_item.last;

endmodule

`default_nettype wire

// ===== rtl/core/lpmd_parser.sv =====
// Header collection and payload tracking state machine of the deframer.
// Processes one registered byte per step and forms at most one result.
// Depends on lpmd_pkg.
`default_nettype none

module lpmd_parser (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               step,
    input  wire logic [lpmd_pkg::BYTE_W-1:0]        byte_in,
    input  wire logic [lpmd_pkg::MAX_W-1:0]         max_message_bytes,
    output lpmd_pkg::result_slot_t                  result
);

    lpmd_pkg::phase_t                   phase_reg, phase_next;
    logic [1:0]                         header_count_reg, header_count_next;
    logic [lpmd_pkg::FIELD_W-1:0]       type_reg, type_next;
    logic [lpmd_pkg::FIELD_W-1:0]       length_reg, length_next;
    logic [lpmd_pkg::FIELD_W-1:0]       remaining_reg, remaining_next;
    logic [lpmd_pkg::FIELD_W-1:0]       rem_dec;
    logic [lpmd_pkg::MAX_W-1:0]         limit;
    logic [lpmd_pkg::MAX_W-1:0]         msg_size;

    assign rem_dec  = remaining_reg - 16'd1;
    assign limit    = (max_message_bytes < lpmd_pkg::HEADER_BYTES) ?
                      lpmd_pkg::HEADER_BYTES : max_message_bytes;
    assign msg_size = {1'b0, length_next} + lpmd_pkg::HEADER_BYTES;

    always_comb
    begin
        phase_next        = phase_reg;
        header_count_next = header_count_reg;
        type_next         = type_reg;
        length_next       = length_reg;
        remaining_next    = remaining_reg;
        result            = '0;

        case (phase_reg)
            lpmd_pkg::PH_FORWARD:
            begin
                remaining_next          = rem_dec;
                result.valid            = 1'b1;
                result.data.data_byte   = byte_in;
                result.data.kind        = lpmd_pkg::KIND_PAYLOAD;
                result.data.last        = (rem_dec == '0);
                if (rem_dec == '0)
                begin
                    phase_next = lpmd_pkg::PH_HEADER;
                end
            end
            lpmd_pkg::PH_DISCARD:
            begin
                remaining_next = rem_dec;
                if (rem_dec == '0)
                begin
                    phase_next = lpmd_pkg::PH_HEADER;
                end
            end
            default:
            begin
                phase_next = lpmd_pkg::PH_HEADER;
                case (header_count_reg)
                    lpmd_pkg::HDR_TYPE_LO: type_next   = {8'd0, byte_in};
                    lpmd_pkg::HDR_TYPE_HI: type_next   = {byte_in, type_reg[7:0]};
                    lpmd_pkg::HDR_LEN_LO:  length_next = {8'd0, byte_in};
                    default:               length_next = {byte_in, length_reg[7:0]};
                endcase

                if (header_count_reg != lpmd_pkg::HDR_LEN_HI)
                begin
                    header_count_next = header_count_reg + 2'd1;
                end
                else
                begin
                    header_count_next = '0;
                    remaining_next    = length_next;
                    if (msg_size > limit)
                    begin
                        result.valid     = 1'b1;
                        result.data.kind = lpmd_pkg::KIND_DROPPED;
                        result.data.last = 1'b1;
                        if (length_next != '0)
                        begin
                            phase_next = lpmd_pkg::PH_DISCARD;
                        end
                    end
                    else if (length_next == '0)
                    begin
                        result.valid     = 1'b1;
                        result.data.kind = lpmd_pkg::KIND_EMPTY;
                        result.data.last = 1'b1;
                    end
                    else
                    begin
                        phase_next = lpmd_pkg::PH_FORWARD;
                    end
                end
            end
        endcase

        // The header fields seen by a result are those after this byte's update.
        result.data.msg_type    = type_next;
        result.data.payload_len = length_next;
        result.valid            = result.valid & step;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= lpmd_pkg::PH_HEADER;
            header_count_reg <= '0;
            type_reg         <= '0;
            length_reg       <= '0;
            remaining_reg    <= '0;
        end
        else if (step)
        begin
            phase_reg        <= phase_next;
            header_count_reg <= header_count_next;
            type_reg         <= type_next;
            length_reg       <= length_next;
            remaining_reg    <= remaining_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_forward_has_bytes: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == lpmd_pkg::PH_FORWARD || phase_reg == lpmd_pkg::PH_DISCARD)
        |-> remaining_reg != '0)
        else $error("payload phase entered with no bytes remaining");

    a_count_only_in_header: assert property (@(posedge clk) disable iff (!rst_n)
        header_count_reg != '0 |-> phase_reg == lpmd_pkg::PH_HEADER)
        else $error("header count nonzero outside header collection");

    a_empty_has_zero_len: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.data.kind == lpmd_pkg::KIND_EMPTY)
        |-> result.data.payload_len == '0)
        else $error("empty message result with nonzero length");

    a_last_payload_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.data.kind == lpmd_pkg::KIND_PAYLOAD && result.data.last)
        |=> phase_reg == lpmd_pkg::PH_HEADER)
        else $error("last payload byte did not return to header collection");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/lpmd_out_buf.sv =====
// Two-entry result buffer that drives the master-side stream.
// Its room flag is registered so the slave-side ready has no path from m_axis_tready.
// Depends on lpmd_pkg.
`default_nettype none

module lpmd_out_buf (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire lpmd_pkg::result_slot_t  push_item,
    output logic                         room,
    output logic                         out_valid,
    input  wire logic                    out_ready,
    output lpmd_pkg::result_t            out_item
);

    logic [1:0]         count_reg, count_next;
    lpmd_pkg::result_t  head_reg;
    lpmd_pkg::result_t  skid_reg;
    logic               pop;
    logic               push;

    assign out_valid = (count_reg != 2'd0);
    assign out_item  = head_reg;
    assign room      = (count_reg != 2'd2);
    assign pop       = out_valid & out_ready;
    assign push      = push_item.valid;

    always_comb
    begin
        count_next = count_reg;
        case ({push, pop})
            2'b10:   count_next = count_reg + 2'd1;
            2'b01:   count_next = count_reg - 2'd1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (pop && count_reg == 2'd2)
        begin
            head_reg <= skid_reg;
        end
        if (push)
        begin
            if (count_reg == 2'd0 || (count_reg == 2'd1 && pop))
            begin
                head_reg <= push_item.data;
            end
            else
            begin
                skid_reg <= push_item.data;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (count_reg != 2'd2 || pop))
        else $error("result pushed into a full buffer");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3)
        else $error("result buffer count out of range");

    a_hold_while_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(out_item)))
        else $error("output item changed while stalled");
`endif

endmodule

`default_nettype wire
